>>> sv/altitude_statistics_tracker_macros.svh
// ----------------------------------------------------------------------------
// Altitude statistics tracker assertion macros
// Shared shorthand for the concurrent checks of the tracker, all clocked on
// the rising edge of clock and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_STATISTICS_TRACKER_MACROS_SVH
`define ALTITUDE_STATISTICS_TRACKER_MACROS_SVH

// A condition that must hold at every clock edge.
`define AST_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define AST_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define AST_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ast_pkg.sv
// ----------------------------------------------------------------------------
// Altitude statistics tracker package
// Register indexes, commands, field widths, reset values and limits, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ast_pkg;

   localparam int WINDOW_W    = 9;
   localparam int HYST_W      = 22;
   localparam int TOTAL_W     = 40;
   localparam int CSR_INDEX_W = 1;
   localparam int WINDOW_CAP  = 256;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd60;
   localparam logic [WINDOW_W-1:0] WINDOW_MIN   = 9'd2;
   localparam logic [HYST_W-1:0]   HYST_RESET   = 22'd6400;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_HYSTERESIS    = 1'b1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_RESET  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_PUBLISH
   } ast_state_type;

endpackage

`default_nettype wire

>>> sv/altitude_statistics_tracker.sv
// A result is registered when it leaves the publish state, after its transaction's update and divide states.
// No new transaction is taken until the last result is published, a pace set mostly by the
// restoring divider for the average, which retires one quotient bit per cycle.
// A finished result waits in its own output register while the next transaction is taken.
// Reset is synchronous; no clearing pass, since ring entries are only read once written.
// ----------------------------------------------------------------------------
// Altitude statistics tracker
// Keeps the latest, windowed mean, minimum and maximum altitude and the
// hysteresis-gated ascent and descent totals over a stream of samples.
// ----------------------------------------------------------------------------
`default_nettype none

module altitude_statistics_tracker #(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_current_altitude,
   output logic signed [SAMPLE_BITS-1:0]         rsp_average_altitude,
   output logic        [ast_pkg::TOTAL_W-1:0]    rsp_total_ascent,
   output logic        [ast_pkg::TOTAL_W-1:0]    rsp_total_descent,
   output logic signed [SAMPLE_BITS-1:0]         rsp_min_altitude,
   output logic signed [SAMPLE_BITS-1:0]         rsp_max_altitude,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [ast_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [ast_pkg::HYST_W-1:0]     csr_wdata
);

   import ast_pkg::*;

   localparam int HEAD_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int SLOT_W = ((HEAD_W > WINDOW_W) ? HEAD_W : WINDOW_W) + 1;
   // The window never exceeds 256 entries, so eight guard bits keep the sum exact.
   localparam int SUM_W  = SAMPLE_BITS + 8;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int DELTA_W = (SAMPLE_BITS > HYST_W) ? SAMPLE_BITS + 1 : HYST_W + 1;

   localparam logic [WINDOW_W-1:0] WIN_LIMIT =
      (MAX_WINDOW < WINDOW_CAP) ? WINDOW_W'(MAX_WINDOW) : WINDOW_W'(WINDOW_CAP);
   localparam logic [WINDOW_W-1:0] ACTIVE_RESET =
      (WINDOW_RESET < WIN_LIMIT) ? WINDOW_RESET : WIN_LIMIT;

   // Sequencer
   ast_state_type state_ff, state_in;

   // Statistics state
   logic        [HEAD_W-1:0]      head_ff, head_in;
   logic        [WINDOW_W-1:0]    count_ff, count_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] ref_ff, ref_in;
   logic signed [SAMPLE_BITS-1:0] last_ff, last_in;
   logic        [TOTAL_W-1:0]     ascent_ff, ascent_in;
   logic        [TOTAL_W-1:0]     descent_ff, descent_in;
   logic signed [SAMPLE_BITS-1:0] lowest_ff, lowest_in;
   logic signed [SAMPLE_BITS-1:0] highest_ff, highest_in;
   logic        [WINDOW_W-1:0]    active_ff, active_in;

   // Configuration registers
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [HYST_W-1:0]   hyst_ff, hyst_in;

   // Captured transaction
   logic                          item_cmd_ff;
   logic signed [SAMPLE_BITS-1:0] item_sample_ff;

   // Sample ring
   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] ring_rdata_ff;
   logic                          ring_we;
   logic        [HEAD_W-1:0]      ring_waddr;
   logic signed [SAMPLE_BITS-1:0] ring_wdata;

   // Divider
   logic [SUM_W-1:0]    quot_ff, quot_in;
   logic [WINDOW_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [WINDOW_W:0]   trial;
   logic [SUM_W-1:0]    avg_mag;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_current_ff, out_average_ff, out_min_ff, out_max_ff;
   logic        [TOTAL_W-1:0]     out_ascent_ff, out_descent_ff;

   // Sequencer controls
   logic accept;
   logic out_free;
   logic publish;
   logic divide_last;

   // Update datapath temporaries
   logic signed [SAMPLE_BITS-1:0] s;
   logic signed [DELTA_W-1:0]     delta;
   logic signed [DELTA_W-1:0]     neg_delta;
   logic signed [DELTA_W-1:0]     hyst_s;
   logic        [TOTAL_W:0]       total_sum;
   logic        [SLOT_W-1:0]      slot_sum;
   logic                          full;
   logic        [WINDOW_W-1:0]    wl;

   // ----------------------------------------------------------------------
   // Next state
   // ----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (divide_last) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ----------------------------------------------------------------------
   // Sequencer outputs
   // ----------------------------------------------------------------------
   always_comb begin
      req_stall   = 1'b1;
      publish     = 1'b0;
      ring_we     = 1'b0;
      divide_last = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_stall   = 1'b0;
         ST_UPDATE:  ring_we     = 1'b1;
         ST_DIVIDE:  divide_last = (step_ff == STEP_W'(SUM_W - 1));
         ST_PUBLISH: publish     = out_free;
         default:    req_stall   = 1'b1;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // ----------------------------------------------------------------------
   // Configuration writes
   // ----------------------------------------------------------------------
   always_comb begin
      window_in = window_ff;
      hyst_in   = hyst_ff;
      wl        = csr_wdata[WINDOW_W-1:0];
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH: begin
               if (wl < WINDOW_MIN) begin
                  window_in = WINDOW_MIN;
               end else if (wl > WIN_LIMIT) begin
                  window_in = WIN_LIMIT;
               end else begin
                  window_in = wl;
               end
            end
            REG_HYSTERESIS: hyst_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // ----------------------------------------------------------------------
   // Statistics update, done in the single update cycle
   // ----------------------------------------------------------------------
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      ref_in     = ref_ff;
      last_in    = last_ff;
      ascent_in  = ascent_ff;
      descent_in = descent_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      active_in  = active_ff;
      ring_waddr = '0;
      ring_wdata = last_ff;
      s          = item_sample_ff;
      delta      = DELTA_W'(item_sample_ff) - DELTA_W'(ref_ff);
      neg_delta  = -delta;
      hyst_s     = DELTA_W'(hyst_ff);
      total_sum  = '0;
      full       = (count_ff >= active_ff);
      slot_sum   = SLOT_W'(head_ff) + SLOT_W'(count_ff);
      if (slot_sum >= SLOT_W'(MAX_WINDOW)) begin
         slot_sum = slot_sum - SLOT_W'(MAX_WINDOW);
      end

      if (state_ff == ST_UPDATE) begin
         if (item_cmd_ff == CMD_RESET) begin
            // Restart the window with the last sample as its only entry.
            head_in    = '0;
            count_in   = WINDOW_W'(1);
            sum_in     = SUM_W'(last_ff);
            ascent_in  = '0;
            descent_in = '0;
            active_in  = window_ff;
            lowest_in  = last_ff;
            highest_in = last_ff;
            ring_waddr = '0;
            ring_wdata = last_ff;
         end else begin
            last_in    = s;
            ring_wdata = s;
            if (count_ff == '0) begin
               ref_in     = s;
               lowest_in  = s;
               highest_in = s;
            end else begin
               if (delta > hyst_s) begin
                  total_sum = {1'b0, ascent_ff} + (TOTAL_W + 1)'($unsigned(delta));
                  ascent_in = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                  ref_in    = s;
               end
               if (neg_delta > hyst_s) begin
                  total_sum  = {1'b0, descent_ff} + (TOTAL_W + 1)'($unsigned(neg_delta));
                  descent_in = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                  ref_in     = s;
               end
               if (s > highest_ff) highest_in = s;
               if (s < lowest_ff) lowest_in = s;
            end
            // In both cases the new sample lands at head + count; a full
            // window also drops its oldest entry and advances the head.
            ring_waddr = slot_sum[HEAD_W-1:0];
            if (full) begin
               sum_in  = sum_ff - SUM_W'(ring_rdata_ff) + SUM_W'(s);
               head_in = (head_ff == HEAD_W'(MAX_WINDOW - 1)) ? '0 : head_ff + 1'b1;
            end else begin
               sum_in   = sum_ff + SUM_W'(s);
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // Restoring divider on the magnitude of the sum, one bit per cycle
   // ----------------------------------------------------------------------
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quot_ff[SUM_W-1]};
      if (state_ff == ST_UPDATE) begin
         neg_in  = sum_in[SUM_W-1];
         quot_in = sum_in[SUM_W-1] ? $unsigned(-sum_in) : $unsigned(sum_in);
         rem_in  = '0;
         step_in = '0;
      end else if (state_ff == ST_DIVIDE) begin
         if (trial >= {1'b0, count_ff}) begin
            rem_in  = WINDOW_W'(trial - {1'b0, count_ff});
            quot_in = {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[WINDOW_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
      end
   end

   assign avg_mag = neg_ff ? -quot_ff : quot_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ----------------------------------------------------------------------
   // Registers
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         ref_ff       <= '0;
         last_ff      <= '0;
         ascent_ff    <= '0;
         descent_ff   <= '0;
         lowest_ff    <= '0;
         highest_ff   <= '0;
         active_ff    <= ACTIVE_RESET;
         window_ff    <= ACTIVE_RESET;
         hyst_ff      <= HYST_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ref_ff       <= ref_in;
         last_ff      <= last_in;
         ascent_ff    <= ascent_in;
         descent_ff   <= descent_in;
         lowest_ff    <= lowest_in;
         highest_ff   <= highest_in;
         active_ff    <= active_in;
         window_ff    <= window_in;
         hyst_ff      <= hyst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_cmd_ff    <= req_cmd;
         item_sample_ff <= req_sample_value;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      if (publish) begin
         out_current_ff <= last_ff;
         out_average_ff <= avg_mag[SAMPLE_BITS-1:0];
         out_ascent_ff  <= ascent_ff;
         out_descent_ff <= descent_ff;
         out_min_ff     <= lowest_ff;
         out_max_ff     <= highest_ff;
      end
   end

   // The oldest entry is read every cycle; it is used only in the update cycle.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rdata_ff <= ring_mem[head_ff];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_current_altitude = out_current_ff;
   assign rsp_average_altitude = out_average_ff;
   assign rsp_total_ascent     = out_ascent_ff;
   assign rsp_total_descent    = out_descent_ff;
   assign rsp_min_altitude     = out_min_ff;
   assign rsp_max_altitude     = out_max_ff;

   // ----------------------------------------------------------------------
   // Assertions
   // ----------------------------------------------------------------------
`include "altitude_statistics_tracker_macros.svh"

   `AST_ALWAYS(a_count_in_window, count_ff <= active_ff, "entry count exceeds the active window")
   `AST_IMPLIES(a_divisor_nonzero, state_ff == ST_DIVIDE, count_ff != '0, "divide by an empty window")
   `AST_NEXT(a_accept_to_update, accept, state_ff == ST_UPDATE, "accepted transaction not updated")
   `AST_IMPLIES(a_result_from_publish, $rose(rsp_valid_ff), $past(state_ff) == ST_PUBLISH, "result raised outside publish")

endmodule

`default_nettype wire
